// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the link count table.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cltt_pkg.sv =====
// Shared types and constants for the column link count table.
// No dependencies; imported by every module of the block.
package cltt_pkg;

  localparam int MAX_LINKS_DEF = 16;
  localparam int KEY_W         = 49;
  localparam int CNT_W         = 16;
  localparam int IDX_OUT_W     = 4;
  localparam int IN_TDATA_W    = 56;
  localparam int OUT_TDATA_W   = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CNT_W-1:0]     entry_count;
    logic [CNT_W-1:0]     total_count;
    logic                 is_new;
    logic                 dropped;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_READ,
    BK_WRITE
  } bk_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/cltt_front.sv =====
// Front end of the link count table: accepts items, decodes the command and
// builds the link key, and holds them in a two-entry queue. Uses cltt_pkg.
module cltt_front
  import cltt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  q_valid,
  output item_t                 q_item,
  input  logic                  q_pop
);

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       pop;
  item_t      item_in;

  // Key is position, offset, base from the most significant end down.
  always_comb begin
    item_in.op  = in_tuser ? OP_CLEAR : OP_UPDATE;
    item_in.key = {in_tdata[24:0], in_tdata[40:25], in_tdata[48:41]};
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign pop       = q_valid && q_pop;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== rtl/core/cltt_back.sv =====
// Back end of the link count table: key store, count memory, column total
// and the sequencer that applies one queued item at a time. Uses cltt_pkg.
module cltt_back
  import cltt_pkg::*;
#(
  parameter int MAX_LINKS = MAX_LINKS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  localparam int IDX_W = $clog2(MAX_LINKS);
  localparam int LU_W  = $clog2(MAX_LINKS + 1);

  bk_state_t        state_r, state_nxt;
  item_t            item_r;
  logic [KEY_W-1:0] keys_r [MAX_LINKS];
  logic [CNT_W-1:0] cnt_mem [MAX_LINKS];
  logic [CNT_W-1:0] rd_cnt_r;
  logic [LU_W-1:0]  used_r;
  logic [CNT_W-1:0] total_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;

  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic             full;
  logic             finish;
  logic             is_clear;
  logic             append;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] cnt_new;

  // Stored keys are unique, so at most one slot matches and the index is an OR.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_LINKS; i++) begin
      if ((LU_W'(i) < used_r) && (keys_r[i] == item_r.key)) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign full     = (used_r == LU_W'(MAX_LINKS));
  assign is_clear = (item_r.op == OP_CLEAR);
  assign append   = !is_clear && !hit_r && !full;
  assign wr_idx   = hit_r ? hit_idx_r : used_r[IDX_W-1:0];
  assign cnt_new  = hit_r ? sat_inc(rd_cnt_r) : CNT_W'(1);
  assign finish   = (state_r == BK_WRITE) && res_ready;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_nxt = BK_MATCH;
        end
      end
      BK_MATCH: state_nxt = BK_READ;
      BK_READ:  state_nxt = BK_WRITE;
      BK_WRITE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    if (!is_clear) begin
      res.total_count = sat_inc(total_r);
      if (hit_r || !full) begin
        res.entry_index = IDX_OUT_W'(wr_idx);
        res.entry_count = cnt_new;
        res.is_new      = !hit_r;
      end else begin
        res.dropped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      used_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        if (is_clear) begin
          used_r  <= '0;
          total_r <= '0;
        end else begin
          total_r <= sat_inc(total_r);
          if (append) begin
            used_r <= used_r + LU_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      item_r <= q_item;
    end
    if (state_r == BK_MATCH) begin
      hit_r     <= hit_any;
      hit_idx_r <= hit_idx;
    end
    rd_cnt_r <= cnt_mem[hit_idx_r];
    if (finish && !is_clear && (hit_r || !full)) begin
      cnt_mem[wr_idx] <= cnt_new;
    end
    if (finish && append) begin
      keys_r[wr_idx] <= item_r.key;
    end
  end

endmodule

// ===== rtl/core/column_link_count_table_top.sv =====
// Top level of the column link count table: input queue, table back end and
// output register. Uses cltt_pkg, cltt_front, cltt_back and assert_macros.svh.
//
// This block keeps the predecessor-link table of one consensus column. Each
// update transfer adds one to the column total and either bumps the count of
// a stored link with the same key (position, offset, base) or appends the key
// as a new link with count 1. When all MAX_LINKS slots are in use a new key is
// discarded and the result carries the dropped flag. A clear transfer empties
// the table and zeroes the total. Counts and the total saturate at 65535.
// Every input transfer yields exactly one result transfer, in order. In the
// back end an item steps through dequeue, parallel key compare, count memory
// read, then count write and result, which holds while the output stalls. A
// new item is taken only after the last one is done: the count memory's
// read-modify-write must finish before the next item can look at the table.
// A two-entry queue in front and a result register behind let either side
// stall without holding up the other. No clearing pass is needed after reset.
`include "assert_macros.svh"

module column_link_count_table_top
  import cltt_pkg::*;
#(
  parameter int MAX_LINKS = MAX_LINKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // prev_pos[24:0], prev_offset[40:25], prev_base[48:41], zero[55:49]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd: 0 update, 1 clear
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // entry_index[3:0], entry_count[19:4], total_count[35:20], zero[39:36]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // is_new[0], dropped[1]
  output logic [1:0]             out_tuser
);

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  logic    res_valid;
  result_t res;
  logic    res_ready;

  logic    out_valid_r;
  result_t out_res_r;

  cltt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  cltt_back #(
    .MAX_LINKS (MAX_LINKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // The result register takes a new result whenever it is empty or its
  // current content is being transferred out in the same cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.total_count, out_res_r.entry_count,
                       out_res_r.entry_index};
  assign out_tuser  = {out_res_r.dropped, out_res_r.is_new};

  // A result is never both a fresh append and a drop.
  `ASSERT_IMPL(a_new_xor_drop, clk, rst_n, out_tvalid, !(out_tuser[0] && out_tuser[1]), "new and dropped both set")
  // A freshly appended link always starts at a count of one.
  `ASSERT_IMPL(a_new_count_one, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[19:4] == 16'd1, "new link count is not one")
  // A dropped key reports slot zero with count zero, but a nonzero total.
  `ASSERT_IMPL(a_drop_fields, clk, rst_n, out_tvalid && out_tuser[1], (out_tdata[19:0] == 20'd0) && (out_tdata[35:20] != 16'd0), "dropped result fields wrong")
  // A result accepted into an empty output register shows up the next cycle.
  `ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid && !out_valid_r, out_tvalid, "result lost on its way out")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for column_link_count_table_top: a stream driver and a
// result monitor around a behavioral model of the link table. Needs cltt_pkg.

module tb;
  import cltt_pkg::*;

  // One pending input transfer: the command and the link key fields.
  typedef struct packed {
    op_t         cmd;
    logic [24:0] pos;
    logic [15:0] off;
    logic [7:0]  base;
  } link_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // prev_pos[24:0], prev_offset[40:25], prev_base[48:41], zero[55:49]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // cmd: 0 update, 1 clear
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // entry_index[3:0], entry_count[19:4], total_count[35:20], zero[39:36]
  logic [OUT_TDATA_W-1:0] out_tdata;
  // is_new[0], dropped[1]
  logic [1:0]             out_tuser;

  column_link_count_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectations.
  link_item_t  pending_links[$];
  result_t     link_results_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_fire = 1'b0;

  // Model of the table, kept in step with every accepted input transfer.
  logic [KEY_W-1:0] tab_keys [MAX_LINKS_DEF];
  logic [CNT_W-1:0] tab_counts [MAX_LINKS_DEF];
  int               tab_used = 0;
  logic [CNT_W-1:0] tab_total = '0;

  int fault_count = 0;
  int n_updates = 0;
  int n_clears = 0;
  int n_new = 0;
  int n_hits = 0;
  int n_drops = 0;
  int n_saturated = 0;

  // Applies one transfer to the table model and returns the result it must produce.
  function automatic result_t predict_link_update(input link_item_t it);
    result_t          r;
    logic [KEY_W-1:0] k;
    bit               hit;
    r   = '0;
    hit = 1'b0;
    if (it.cmd == OP_CLEAR) begin
      for (int i = 0; i < MAX_LINKS_DEF; i++) tab_counts[i] = '0;
      tab_used  = 0;
      tab_total = '0;
    end else begin
      k = {it.pos, it.off, it.base};
      if (tab_total != CNT_MAX) tab_total = tab_total + CNT_W'(1);
      // Only slots that have been filled since the last clear take part in the search.
      for (int i = 0; i < tab_used; i++) begin
        if (tab_keys[i] == k) begin
          if (tab_counts[i] != CNT_MAX) tab_counts[i] = tab_counts[i] + CNT_W'(1);
          r.entry_index = i[IDX_OUT_W-1:0];
          r.entry_count = tab_counts[i];
          hit = 1'b1;
          break;
        end
      end
      if (!hit) begin
        if (tab_used >= MAX_LINKS_DEF) begin
          r.dropped = 1'b1;
        end else begin
          tab_keys[tab_used]   = k;
          tab_counts[tab_used] = CNT_W'(1);
          r.entry_index        = tab_used[IDX_OUT_W-1:0];
          r.entry_count        = CNT_W'(1);
          r.is_new             = 1'b1;
          tab_used++;
        end
      end
    end
    r.total_count = tab_total;
    return r;
  endfunction

  // Reports of mismatches are capped so a badly broken block cannot flood the log;
  // every mismatch still counts as a failure.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 100) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Driver: inputs move at the falling edge. A valid item is held until it is taken.
  always @(negedge clk) begin
    link_item_t nxt;
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (pending_links.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_links.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.cmd;
          in_tdata  <= {7'b0, nxt.base, nxt.off, nxt.pos};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: at the rising edge, check a result transfer against the oldest
  // expectation and turn an accepted input transfer into a new expectation.
  always @(posedge clk) begin
    link_item_t acc;
    result_t    want;
    result_t    got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.entry_index = out_tdata[3:0];
        got.entry_count = out_tdata[19:4];
        got.total_count = out_tdata[35:20];
        got.is_new      = out_tuser[0];
        got.dropped     = out_tuser[1];
        if (link_results_due.size() == 0) begin
          fault_count++;
          $error("result transfer with no expectation waiting");
        end else begin
          want = link_results_due.pop_front();
          check_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          check_field("total_count", 32'(want.total_count), 32'(got.total_count));
          check_field("is_new", 32'(want.is_new), 32'(got.is_new));
          check_field("dropped", 32'(want.dropped), 32'(got.dropped));
        end
      end
      if (in_tvalid && in_tready) begin
        acc.cmd  = op_t'(in_tuser);
        acc.pos  = in_tdata[24:0];
        acc.off  = in_tdata[40:25];
        acc.base = in_tdata[48:41];
        want = predict_link_update(acc);
        link_results_due.push_back(want);
        if (acc.cmd == OP_CLEAR) n_clears++;
        else n_updates++;
        if (want.is_new) n_new++;
        if (want.dropped) n_drops++;
        if (acc.cmd == OP_UPDATE && !want.is_new && !want.dropped) n_hits++;
        if (want.entry_count == CNT_MAX || want.total_count == CNT_MAX) n_saturated++;
      end
    end
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  function automatic link_item_t mk_link(input op_t c, input logic [24:0] p,
                                         input logic [15:0] o, input logic [7:0] b);
    link_item_t it;
    it.cmd  = c;
    it.pos  = p;
    it.off  = o;
    it.base = b;
    return it;
  endfunction

  // A random key; position -1 (no previous base) shows up now and then.
  function automatic link_item_t rand_link(input op_t c);
    logic [24:0] p;
    if ($urandom_range(99) < 8) p = '1;
    else p = 25'($urandom_range(0, 24'hFFFFFF));
    return mk_link(c, p, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endfunction

  // Waits until every queued item has been taken and every result has come back.
  task automatic wait_drained();
    while (pending_links.size() != 0 || in_tvalid || link_results_due.size() != 0)
      @(posedge clk);
  endtask

  // Random columns: each builds a pool of keys, repeats them in random order so that
  // links get hit many times, and ends with a clear. Larger pools overflow the table.
  // A few stray clears and one-off keys are mixed in as noise.
  task automatic run_random_columns(input int n_items);
    link_item_t pool[$];
    link_item_t k;
    int         made;
    int         pool_size;
    int         col_len;
    int         roll;
    made = 0;
    while (made < n_items) begin
      pool.delete();
      pool_size = ($urandom_range(99) < 70) ? $urandom_range(1, 16) : $urandom_range(17, 28);
      for (int i = 0; i < pool_size; i++) begin
        k = rand_link(OP_UPDATE);
        // Neighbors of an earlier key differ in a single field.
        if (i > 0 && $urandom_range(99) < 30) begin
          k = pool[$urandom_range(0, i - 1)];
          case ($urandom_range(0, 2))
            0: k.pos = k.pos + 25'd1;
            1: k.off = k.off ^ 16'(1 << $urandom_range(0, 15));
            default: k.base = k.base ^ 8'(1 << $urandom_range(0, 7));
          endcase
        end
        pool.push_back(k);
      end
      col_len = $urandom_range(4, 70);
      for (int j = 0; j < col_len && made < n_items; j++) begin
        roll = $urandom_range(99);
        if (roll < 3) pending_links.push_back(rand_link(OP_CLEAR));
        else if (roll < 11) pending_links.push_back(rand_link(OP_UPDATE));
        else pending_links.push_back(pool[$urandom_range(0, pool.size() - 1)]);
        made++;
      end
      pending_links.push_back(rand_link(OP_CLEAR));
      made++;
    end
  endtask

  initial begin
    link_item_t a_key;
    link_item_t b_key;
    link_item_t c_key;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part, no idling: a key with position -1, a key of all ones but
    // the sign bit, a key differing from the first only in that bit, repeats,
    // a clear, then a full table that drops a new key but still counts a repeat.
    a_key = mk_link(OP_UPDATE, '1, 16'h0000, 8'h00);
    b_key = mk_link(OP_UPDATE, 25'h0FF_FFFF, 16'hFFFF, 8'hFF);
    c_key = mk_link(OP_UPDATE, 25'h0FF_FFFF, 16'h0000, 8'h00);
    pending_links.push_back(a_key);
    pending_links.push_back(a_key);
    pending_links.push_back(b_key);
    pending_links.push_back(c_key);
    pending_links.push_back(a_key);
    pending_links.push_back(mk_link(OP_CLEAR, '1, 16'hFFFF, 8'hFF));
    pending_links.push_back(a_key);
    pending_links.push_back(b_key);
    pending_links.push_back(c_key);
    for (int i = 0; i < MAX_LINKS_DEF - 3; i++)
      pending_links.push_back(mk_link(OP_UPDATE, 25'd1, 16'(i), 8'hA5));
    pending_links.push_back(mk_link(OP_UPDATE, 25'd2, 16'h1234, 8'h5A));
    pending_links.push_back(c_key);
    pending_links.push_back(mk_link(OP_CLEAR, '0, 16'h0000, 8'h00));
    wait_drained();

    // Random part under each idling pattern. Every phase ends with the sender
    // holding off until all expected results have come back.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_columns(330);
    wait_drained();
    send_idle_pct  = 67;
    recv_stall_pct = 0;
    run_random_columns(330);
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    run_random_columns(330);
    wait_drained();
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_random_columns(330);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (32) @(posedge clk);
    $display("Covered %0d updates (%0d new links, %0d repeat hits, %0d dropped when full)",
             n_updates, n_new, n_hits, n_drops);
    $display("and %0d clears; %0d results carried a saturated count.", n_clears, n_saturated);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
